@@ rtl/core/ifls_pkg.sv @@
// ----------------------------------------------------------------------------
// ifls_pkg
// Shared widths, payload types and operation codes for the index free list.
// ----------------------------------------------------------------------------
package ifls_pkg;

  localparam int CFG_W = 11;  // node_count register and free count
  localparam int IDX_W = 10;  // node index fields on the ports

  typedef logic [CFG_W-1:0] cnt_t;
  typedef logic [IDX_W-1:0] idx_t;

  localparam logic MODE_POP  = 1'b0;
  localparam logic MODE_PUSH = 1'b1;

endpackage

@@ rtl/core/ifls_link_mem.sv @@
// ----------------------------------------------------------------------------
// ifls_link_mem
// Next-link store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ifls_link_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10,
  parameter int DW    = 11
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/core/index_free_list_stack.sv @@
// ----------------------------------------------------------------------------
// index_free_list_stack
// Free list of node indices held as a linked stack in a next-link memory.
// ----------------------------------------------------------------------------
// A pop transaction hands out the head index: it reads the next-link memory at
// head, then, once the output register is free, moves head to that successor.
// A push, and a pop on an empty list, load their result in the cycle they are
// accepted. Only one transaction is in flight; a new one is taken once the
// previous result has been loaded into the output register. After reset and
// every node_count write, the block rebuilds the chain 0,1,...,node_count-1 by
// writing one link per cycle, holding in_stall until the last link is written.
// node_count writes of 0 act as 1 and values above MAX_NODES act as MAX_NODES;
// pushes of an index at or above node_count, or onto a full list, return ok=0.
// ----------------------------------------------------------------------------
module index_free_list_stack #(
  parameter int MAX_NODES = 1024
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  ifls_pkg::cnt_t cfg_wdata,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic          mode,
  input  ifls_pkg::idx_t push_index,
  output logic          out_valid,
  input  logic          out_stall,
  output logic          ok,
  output ifls_pkg::idx_t pop_index,
  output ifls_pkg::cnt_t free_count
);
  import ifls_pkg::*;

  localparam int AW = $clog2(MAX_NODES);
  localparam int LW = $clog2(MAX_NODES + 1);
  localparam logic [LW-1:0] LIST_END = LW'(MAX_NODES);
  localparam int RESET_INT = (MAX_NODES < 1024) ? MAX_NODES : 1024;
  localparam cnt_t RESET_COUNT = CFG_W'(RESET_INT);

  localparam logic [1:0] ST_INIT = 2'd0;
  localparam logic [1:0] ST_IDLE = 2'd1;
  localparam logic [1:0] ST_READ = 2'd2;

  logic [1:0]    state;
  logic [LW-1:0] head;
  cnt_t          count;
  cnt_t          node_count;
  logic [AW-1:0] sweep;

  logic          in_accept;
  logic          out_free;
  logic          is_pop;
  logic          head_empty;
  logic          push_ok;
  cnt_t          cfg_clamped;
  logic [31:0]   sweep_succ;
  logic          sweep_last;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [LW-1:0] mem_wdata;
  logic          mem_re;
  logic [LW-1:0] mem_rdata;
  logic          load;
  logic          load_ok;
  idx_t          load_index;
  cnt_t          load_count;

  assign out_free   = !out_valid || !out_stall;
  assign in_stall   = (state != ST_IDLE) || !out_free;
  assign in_accept  = in_valid && !in_stall;
  assign is_pop     = (mode == MODE_POP);
  assign head_empty = (head == LIST_END);
  assign push_ok    = ({1'b0, push_index} < node_count) && (count < node_count);

  always_comb begin
    cfg_clamped = cfg_wdata;
    if (cfg_wdata == '0) begin
      cfg_clamped = CFG_W'(1);
    end else if (32'(cfg_wdata) > 32'(MAX_NODES)) begin
      cfg_clamped = CFG_W'(MAX_NODES);
    end
  end

  assign sweep_succ = 32'(sweep) + 32'd1;
  assign sweep_last = (sweep_succ >= 32'(node_count));

  // init sweep and push share the write port; never active together
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = sweep;
    mem_wdata = sweep_last ? LIST_END : LW'(sweep_succ);
    if (state == ST_INIT) begin
      mem_we = 1'b1;
    end else if (in_accept && !is_pop && push_ok) begin
      mem_we    = 1'b1;
      mem_waddr = AW'(push_index);
      mem_wdata = head;
    end
  end

  assign mem_re = in_accept && is_pop && !head_empty;

  ifls_link_mem #(
    .DEPTH (MAX_NODES),
    .AW    (AW),
    .DW    (LW)
  ) u_link_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (head[AW-1:0]),
    .rdata (mem_rdata)
  );

  // result for this cycle, if any
  always_comb begin
    load       = 1'b0;
    load_ok    = 1'b0;
    load_index = '0;
    load_count = count;
    if (state == ST_READ && out_free) begin
      load       = 1'b1;
      load_ok    = 1'b1;
      load_index = IDX_W'(head);
      load_count = (count != '0) ? count - CFG_W'(1) : count;
    end else if (in_accept && !is_pop) begin
      load    = 1'b1;
      load_ok = push_ok;
      if (push_ok) begin
        load_count = count + CFG_W'(1);
      end
    end else if (in_accept && head_empty) begin
      load = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_INIT;
      sweep      <= '0;
      head       <= '0;
      node_count <= RESET_COUNT;
      count      <= RESET_COUNT;
    end else if (cfg_we) begin
      state      <= ST_INIT;
      sweep      <= '0;
      head       <= '0;
      node_count <= cfg_clamped;
      count      <= cfg_clamped;
    end else begin
      count <= load_count;
      case (state)
        ST_INIT: begin
          sweep <= AW'(sweep_succ);
          if (sweep_last) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (mem_re) begin
            state <= ST_READ;
          end else if (in_accept && !is_pop && push_ok) begin
            head <= LW'(push_index);
          end
        end
        ST_READ: begin
          if (out_free) begin
            head  <= mem_rdata;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_INIT;
          sweep <= '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ok         <= load_ok;
      pop_index  <= load_index;
      free_count <= load_count;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= node_count)
    else $error("free count above node_count");

  a_pop_reads: assert property (@(posedge clk) disable iff (rst || cfg_we)
    (in_accept && is_pop && !head_empty) |=> (state == ST_READ))
    else $error("pop with a live head did not wait for the link read");

  a_reject_holds: assert property (@(posedge clk) disable iff (rst || cfg_we)
    (load && !load_ok) |=> ($stable(head) && $stable(count)))
    else $error("rejected transaction changed the list");

  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !load)
    else $error("result loaded over a stalled result");

endmodule
